### hw/rtl/assert_macros.svh
// Assertion macros for the RTL files.
// Define NO_ASSERTIONS to compile every assertion away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Condition holds in the same cycle as the trigger.
`define ASSERT_IMPLIES(label, clk, rst_n, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error(msg);

// Condition holds in the cycle after the trigger.
`define ASSERT_NEXT(label, clk, rst_n, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);

`else

`define ASSERT_IMPLIES(label, clk, rst_n, trig, cond, msg)
`define ASSERT_NEXT(label, clk, rst_n, trig, cond, msg)

`endif

`endif

### hw/rtl/bhv_pkg.sv
`default_nettype none

package bhv_pkg;

    localparam int STATUS_W = 4;
    localparam int POS_W    = 6;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK          = 4'd0,
        ST_SIGNATURE   = 4'd1,
        ST_FILE_SIZE   = 4'd2,
        ST_RESERVED    = 4'd3,
        ST_VERSION     = 4'd4,
        ST_WIDTH       = 4'd5,
        ST_HEIGHT      = 4'd6,
        ST_PLANES      = 4'd7,
        ST_BPP         = 4'd8,
        ST_COMPRESSION = 4'd9,
        ST_PIXEL_SIZE  = 4'd10,
        ST_NO_COLORS   = 4'd11,
        ST_MANY_COLORS = 4'd12,
        ST_TRUE_COLORS = 4'd13,
        ST_IMPORTANT   = 4'd14
    } status_t;

    // Byte positions at which each little-endian field completes
    localparam logic [POS_W-1:0] POS_SIGNATURE   = 6'd1;
    localparam logic [POS_W-1:0] POS_FILE_SIZE   = 6'd5;
    localparam logic [POS_W-1:0] POS_RESERVED    = 6'd9;
    localparam logic [POS_W-1:0] POS_OFFSET      = 6'd13;
    localparam logic [POS_W-1:0] POS_HDR_SIZE    = 6'd17;
    localparam logic [POS_W-1:0] POS_WIDTH       = 6'd21;
    localparam logic [POS_W-1:0] POS_HEIGHT      = 6'd25;
    localparam logic [POS_W-1:0] POS_PLANES      = 6'd27;
    localparam logic [POS_W-1:0] POS_BPP         = 6'd29;
    localparam logic [POS_W-1:0] POS_COMPRESSION = 6'd33;
    localparam logic [POS_W-1:0] POS_DATA_SIZE   = 6'd37;
    localparam logic [POS_W-1:0] POS_COLORS      = 6'd49;
    localparam logic [POS_W-1:0] POS_LAST        = 6'd53;

    localparam logic [15:0] SIGNATURE        = 16'h4D42;
    localparam logic [31:0] INFO_HEADER_SIZE = 32'd40;
    localparam logic [31:0] MAX_COLORS       = 32'd256;
    localparam logic [15:0] BPP_TRUE         = 16'd24;
    localparam logic [15:0] BPP_PALETTE      = 16'd8;
    localparam logic [15:0] PLANES_ONE       = 16'd1;

    typedef struct packed {
        status_t            status;
        logic [30:0]        image_width;
        logic signed [31:0] image_height;
        logic [4:0]         pixel_bits;
        logic [31:0]        color_count;
        logic [31:0]        important_count;
        logic [31:0]        data_offset;
        logic [31:0]        data_size;
    } result_t;

endpackage

`default_nettype wire

### hw/rtl/bmp_header_validator_top.sv
// Channel  Handshake             Payload
// in       in_valid / in_stall    byte_value, first_byte
// out      out_valid / out_stall  status, image_width .. data_size
// cfg      cfg_valid / cfg_ready  measured_file_size
//
// One header byte is taken every cycle while in_stall is low; the result of the byte
// that completes it is registered in the result register, or in the skid stage.
// A one-beat skid stage behind the result register keeps bytes flowing while a
// result waits; in_stall rises only when both hold a result.
// rst_n clears the handshake state and leaves the parser waiting for first_byte.
// cfg_ready is always high; the size register is sampled when byte 5 arrives.
`default_nettype none

module bmp_header_validator_top
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,

    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [7:0]                    byte_value,
    input  wire logic                          first_byte,

    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [bhv_pkg::STATUS_W-1:0]       status,
    output logic [30:0]                        image_width,
    output logic signed [31:0]                 image_height,
    output logic [4:0]                         pixel_bits,
    output logic [31:0]                        color_count,
    output logic [31:0]                        important_count,
    output logic [31:0]                        data_offset,
    output logic [31:0]                        data_size,

    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [31:0]                   measured_file_size
);
    import bhv_pkg::*;

    logic [31:0]      meas_size_reg;

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [31:0]      asm_reg;
    logic             stopped_reg, stopped_next;
    logic [31:0]      file_size_reg, file_size_next;
    logic [31:0]      offset_reg, offset_next;
    logic [31:0]      width_reg, width_next;
    logic [31:0]      height_reg, height_next;
    logic [15:0]      bits_reg, bits_next;
    logic [31:0]      size_reg, size_next;
    logic [31:0]      colors_reg, colors_next;

    logic             out_valid_reg, out_valid_next;
    logic             skid_valid_reg, skid_valid_next;
    result_t          out_reg, skid_reg;

    logic             in_fire, out_fire, live, res_hit, res_vld;
    logic [POS_W-1:0] pos;
    logic [31:0]      asm_prev, v32, important;
    logic [15:0]      v16;
    logic             bpp8, bpp24;
    status_t          res_status;
    result_t          res;

    assign cfg_ready = 1'b1;
    assign in_stall  = skid_valid_reg;
    assign in_fire   = in_valid && !in_stall;
    assign out_fire  = out_valid_reg && !out_stall;
    assign live      = first_byte || !stopped_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            meas_size_reg <= '0;
        else if (cfg_valid && cfg_ready)
            meas_size_reg <= measured_file_size;
    end

    // Field checks on the byte that completes each field
    always_comb
    begin
        pos      = first_byte ? '0 : pos_reg;
        asm_prev = first_byte ? '0 : asm_reg;
        v32      = {byte_value, asm_prev[31:8]};
        v16      = v32[31:16];

        file_size_next = first_byte ? '0 : file_size_reg;
        offset_next    = first_byte ? '0 : offset_reg;
        width_next     = first_byte ? '0 : width_reg;
        height_next    = first_byte ? '0 : height_reg;
        bits_next      = first_byte ? '0 : bits_reg;
        size_next      = first_byte ? '0 : size_reg;
        colors_next    = first_byte ? '0 : colors_reg;

        bpp8       = bits_next == BPP_PALETTE;
        bpp24      = bits_next == BPP_TRUE;
        res_status = ST_OK;
        res_hit    = 1'b0;
        important  = '0;

        case (pos)
            POS_SIGNATURE:
                if (v16 != SIGNATURE) res_status = ST_SIGNATURE;
            POS_FILE_SIZE:
            begin
                file_size_next = v32;
                if (v32 != meas_size_reg) res_status = ST_FILE_SIZE;
            end
            POS_RESERVED:
                if (v32 != '0) res_status = ST_RESERVED;
            POS_OFFSET:
                offset_next = v32;
            POS_HDR_SIZE:
                if (v32 != INFO_HEADER_SIZE) res_status = ST_VERSION;
            POS_WIDTH:
            begin
                width_next = v32;
                if (v32 == '0 || v32[31]) res_status = ST_WIDTH;
            end
            POS_HEIGHT:
            begin
                height_next = v32;
                if (v32 == '0) res_status = ST_HEIGHT;
            end
            POS_PLANES:
                if (v16 != PLANES_ONE) res_status = ST_PLANES;
            POS_BPP:
            begin
                bits_next = v16;
                if (v16 != BPP_PALETTE && v16 != BPP_TRUE) res_status = ST_BPP;
            end
            POS_COMPRESSION:
                if (v32 != '0) res_status = ST_COMPRESSION;
            POS_DATA_SIZE:
            begin
                size_next = v32;
                if (v32 != '0 && v32 != (file_size_next - offset_next))
                    res_status = ST_PIXEL_SIZE;
            end
            POS_COLORS:
            begin
                colors_next = v32;
                if (v32 == '0 && bpp8)
                    res_status = ST_NO_COLORS;
                else if (v32 > MAX_COLORS && bpp8)
                    res_status = ST_MANY_COLORS;
                else if (v32 != '0 && bpp24)
                    res_status = ST_TRUE_COLORS;
            end
            POS_LAST:
            begin
                res_hit   = 1'b1;
                important = v32;
                if (v32 > MAX_COLORS && bpp8) res_status = ST_IMPORTANT;
            end
            default:
                res_status = ST_OK;
        endcase

        if (res_status != ST_OK)
            res_hit = 1'b1;

        res_vld      = in_fire && live && res_hit;
        pos_next     = res_hit ? pos : pos + 6'd1;
        stopped_next = res_hit;

        res.status          = res_status;
        res.image_width     = width_next[30:0];
        res.image_height    = signed'(height_next);
        res.pixel_bits      = bits_next[4:0];
        res.color_count     = colors_next;
        res.important_count = important;
        res.data_offset     = offset_next;
        res.data_size       = size_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            asm_reg       <= '0;
            stopped_reg   <= 1'b1;
            file_size_reg <= '0;
            offset_reg    <= '0;
            width_reg     <= '0;
            height_reg    <= '0;
            bits_reg      <= '0;
            size_reg      <= '0;
            colors_reg    <= '0;
        end
        else if (in_fire && live)
        begin
            pos_reg       <= pos_next;
            asm_reg       <= v32;
            stopped_reg   <= stopped_next;
            file_size_reg <= file_size_next;
            offset_reg    <= offset_next;
            width_reg     <= width_next;
            height_reg    <= height_next;
            bits_reg      <= bits_next;
            size_reg      <= size_next;
            colors_reg    <= colors_next;
        end
    end

    // Result register with one skid beat behind it
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (skid_valid_reg)
        begin
            if (out_fire)
                skid_valid_next = 1'b0;
        end
        else if (out_valid_reg && !out_fire)
        begin
            if (res_vld)
                skid_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = res_vld;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_fire)
                out_reg <= skid_reg;
        end
        else if (out_valid_reg && !out_fire)
        begin
            if (res_vld)
                skid_reg <= res;
        end
        else if (res_vld)
        begin
            out_reg <= res;
        end
    end

    assign out_valid       = out_valid_reg;
    assign status          = out_reg.status;
    assign image_width     = out_reg.image_width;
    assign image_height    = out_reg.image_height;
    assign pixel_bits      = out_reg.pixel_bits;
    assign color_count     = out_reg.color_count;
    assign important_count = out_reg.important_count;
    assign data_offset     = out_reg.data_offset;
    assign data_size       = out_reg.data_size;

`include "assert_macros.svh"

    `ASSERT_IMPLIES(a_skid_behind_out, clk, rst_n, skid_valid_reg, out_valid_reg, "skid beat without result beat")
    `ASSERT_IMPLIES(a_ok_only_at_end, clk, rst_n, res_vld && res_status == ST_OK, pos == POS_LAST, "ok result before last header byte")
    `ASSERT_NEXT(a_stop_after_result, clk, rst_n, res_vld, stopped_reg, "parser still running after result")
    `ASSERT_IMPLIES(a_pos_in_header, clk, rst_n, !stopped_reg, pos_reg <= POS_LAST, "byte position beyond header")

endmodule

`default_nettype wire

### tb/bmp_header_validator_top_test.sv
`timescale 1ns / 100ps

module bmp_header_validator_top_test;
    import bhv_pkg::*;

    localparam int CYCLE_LIMIT = 400_000;
    localparam int RANDOM_HEADERS = 8;
    localparam logic [31:0] DIR_SIZE = 32'd2102;

    // Byte index at which each little-endian header field completes
    localparam logic [5:0] END_MAGIC  = 6'd1;
    localparam logic [5:0] END_FSIZE  = 6'd5;
    localparam logic [5:0] END_RSVD   = 6'd9;
    localparam logic [5:0] END_OFFSET = 6'd13;
    localparam logic [5:0] END_INFO   = 6'd17;
    localparam logic [5:0] END_WIDTH  = 6'd21;
    localparam logic [5:0] END_HEIGHT = 6'd25;
    localparam logic [5:0] END_PLANES = 6'd27;
    localparam logic [5:0] END_DEPTH  = 6'd29;
    localparam logic [5:0] END_COMP   = 6'd33;
    localparam logic [5:0] END_DSIZE  = 6'd37;
    localparam logic [5:0] END_COLORS = 6'd49;
    localparam logic [5:0] END_LAST   = 6'd53;

    localparam logic [15:0] BMP_MAGIC   = 16'h4D42;
    localparam logic [31:0] INFO_LEN    = 32'd40;
    localparam logic [31:0] PALETTE_MAX = 32'd256;
    localparam logic [15:0] DEPTH_PAL   = 16'd8;
    localparam logic [15:0] DEPTH_TRUE  = 16'd24;
    localparam logic [15:0] ONE_PLANE   = 16'd1;

    typedef enum logic [3:0] {
        SEL_NONE, SEL_MAGIC, SEL_FSIZE, SEL_RSVD, SEL_OFFSET, SEL_INFO, SEL_WIDTH,
        SEL_HEIGHT, SEL_PLANES, SEL_DEPTH, SEL_COMP, SEL_DSIZE, SEL_COLORS, SEL_IMPORTANT
    } sel_t;

    typedef struct {
        logic [15:0] magic;
        logic [31:0] fsize;
        logic [31:0] rsvd;
        logic [31:0] offset;
        logic [31:0] info_len;
        logic [31:0] width;
        logic [31:0] height;
        logic [15:0] planes;
        logic [15:0] depth;
        logic [31:0] comp;
        logic [31:0] dsize;
        logic [31:0] xres;
        logic [31:0] yres;
        logic [31:0] colors;
        logic [31:0] important;
    } bmp_header_t;

    typedef struct packed {
        logic        true_colour;
        sel_t        sel;
        logic [31:0] val;
        logic [5:0]  len;
        logic        has_want;
        status_t     want;
    } header_case_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  byte_value = 8'd0;
    logic        first_byte = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [STATUS_W-1:0] status;
    logic [30:0] image_width;
    logic signed [31:0] image_height;
    logic [4:0]  pixel_bits;
    logic [31:0] color_count;
    logic [31:0] important_count;
    logic [31:0] data_offset;
    logic [31:0] data_size;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [31:0] measured_file_size = 32'd0;

    // Parser state as the block should hold it
    logic [5:0]  p_pos = 6'd0;
    logic [31:0] p_shift = 32'd0;
    logic        p_halted = 1'b1;
    logic [31:0] p_offset = 32'd0;
    logic [31:0] p_width = 32'd0;
    logic [31:0] p_height = 32'd0;
    logic [15:0] p_depth = 16'd0;
    logic [31:0] p_dsize = 32'd0;
    logic [31:0] p_colors = 32'd0;
    logic [31:0] p_fsize = 32'd0;
    logic [31:0] cfg_size = 32'd0;

    result_t verdict_q [$];
    result_t due;
    int      fail_count = 0;
    int      verdicts_checked = 0;
    int      bytes_parsed = 0;
    int      size_writes = 0;
    int      cycle_count = 0;
    int      hold_req = 0;
    bit      quiet = 1'b0;
    bit      row_seen;
    status_t row_code;

    header_case_t plan [24] = '{
        '{1'b0, SEL_NONE,      32'd0,          6'd54, 1'b1, ST_OK},
        '{1'b0, SEL_MAGIC,     32'h4D43,       6'd54, 1'b1, ST_SIGNATURE},
        '{1'b0, SEL_MAGIC,     32'hB2BD,       6'd2,  1'b1, ST_SIGNATURE},
        '{1'b0, SEL_FSIZE,     32'd2103,       6'd6,  1'b1, ST_FILE_SIZE},
        '{1'b0, SEL_RSVD,      32'h80000000,   6'd10, 1'b1, ST_RESERVED},
        '{1'b0, SEL_INFO,      32'd124,        6'd18, 1'b1, ST_VERSION},
        '{1'b0, SEL_WIDTH,     32'd0,          6'd22, 1'b1, ST_WIDTH},
        '{1'b0, SEL_WIDTH,     32'h80000000,   6'd22, 1'b1, ST_WIDTH},
        '{1'b0, SEL_WIDTH,     32'h7FFFFFFF,   6'd54, 1'b1, ST_OK},
        '{1'b0, SEL_HEIGHT,    32'd0,          6'd26, 1'b1, ST_HEIGHT},
        '{1'b0, SEL_HEIGHT,    32'h80000000,   6'd54, 1'b1, ST_OK},
        '{1'b0, SEL_PLANES,    32'd0,          6'd28, 1'b1, ST_PLANES},
        '{1'b0, SEL_DEPTH,     32'd16,         6'd30, 1'b1, ST_BPP},
        '{1'b0, SEL_DEPTH,     32'hFFE8,       6'd30, 1'b1, ST_BPP},
        '{1'b0, SEL_COMP,      32'd1,          6'd34, 1'b1, ST_COMPRESSION},
        '{1'b0, SEL_DSIZE,     32'hFFFFFFFF,   6'd38, 1'b1, ST_PIXEL_SIZE},
        '{1'b0, SEL_DSIZE,     32'd0,          6'd54, 1'b1, ST_OK},
        '{1'b0, SEL_OFFSET,    32'hFFFFFFFF,   6'd54, 1'b0, ST_OK},
        '{1'b0, SEL_NONE,      32'd0,          6'd30, 1'b0, ST_OK},
        '{1'b0, SEL_COLORS,    32'd0,          6'd50, 1'b1, ST_NO_COLORS},
        '{1'b0, SEL_COLORS,    32'hFFFFFFFF,   6'd50, 1'b1, ST_MANY_COLORS},
        '{1'b0, SEL_IMPORTANT, 32'd257,        6'd54, 1'b1, ST_IMPORTANT},
        '{1'b1, SEL_COLORS,    32'd1,          6'd50, 1'b1, ST_TRUE_COLORS},
        '{1'b1, SEL_IMPORTANT, 32'hFFFFFFFF,   6'd54, 1'b1, ST_OK}
    };

    bmp_header_validator_top DUT
    (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .byte_value         (byte_value),
        .first_byte         (first_byte),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .status             (status),
        .image_width        (image_width),
        .image_height       (image_height),
        .pixel_bits         (pixel_bits),
        .color_count        (color_count),
        .important_count    (important_count),
        .data_offset        (data_offset),
        .data_size          (data_size),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .measured_file_size (measured_file_size)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic logic [431:0] pack_header(bmp_header_t h);
        logic [431:0] v;
        v[0   +: 16] = h.magic;
        v[16  +: 32] = h.fsize;
        v[48  +: 32] = h.rsvd;
        v[80  +: 32] = h.offset;
        v[112 +: 32] = h.info_len;
        v[144 +: 32] = h.width;
        v[176 +: 32] = h.height;
        v[208 +: 16] = h.planes;
        v[224 +: 16] = h.depth;
        v[240 +: 32] = h.comp;
        v[272 +: 32] = h.dsize;
        v[304 +: 32] = h.xres;
        v[336 +: 32] = h.yres;
        v[368 +: 32] = h.colors;
        v[400 +: 32] = h.important;
        return v;
    endfunction

    function automatic bmp_header_t base_header(logic true_colour);
        bmp_header_t h;
        h.magic     = BMP_MAGIC;
        h.fsize     = DIR_SIZE;
        h.rsvd      = 32'd0;
        h.offset    = true_colour ? 32'd54 : 32'd1078;
        h.info_len  = INFO_LEN;
        h.width     = 32'd32;
        h.height    = 32'd32;
        h.planes    = ONE_PLANE;
        h.depth     = true_colour ? DEPTH_TRUE : DEPTH_PAL;
        h.comp      = 32'd0;
        h.dsize     = h.fsize - h.offset;
        h.xres      = 32'd2835;
        h.yres      = 32'd2835;
        h.colors    = true_colour ? 32'd0 : PALETTE_MAX;
        h.important = 32'd0;
        return h;
    endfunction

    function automatic bmp_header_t random_header();
        bmp_header_t h;
        logic pal;
        pal         = 1'($urandom_range(0, 1));
        h.magic     = BMP_MAGIC;
        h.fsize     = cfg_size;
        h.rsvd      = 32'd0;
        h.offset    = $urandom();
        h.info_len  = INFO_LEN;
        h.width     = {1'b0, 31'($urandom())};
        if (h.width == 32'd0)
            h.width = 32'd1;
        h.height    = $urandom();
        if (h.height == 32'd0)
            h.height = 32'hFFFFFFFF;
        h.planes    = ONE_PLANE;
        h.depth     = pal ? DEPTH_PAL : DEPTH_TRUE;
        h.comp      = 32'd0;
        h.dsize     = $urandom_range(0, 1) ? 32'd0 : h.fsize - h.offset;
        h.xres      = $urandom();
        h.yres      = $urandom();
        h.colors    = pal ? 32'($urandom_range(1, 256)) : 32'd0;
        if (!pal || $urandom_range(0, 7) == 0)
            h.important = $urandom();
        else
            h.important = $urandom_range(0, 256);
        return h;
    endfunction

    function automatic bmp_header_t edit_header(bmp_header_t h, sel_t sel, logic [31:0] val);
        case (sel)
            SEL_MAGIC:     h.magic = val[15:0];
            SEL_FSIZE:     h.fsize = val;
            SEL_RSVD:      h.rsvd = val;
            // keep the pixel data size consistent with the new offset
            SEL_OFFSET:
            begin
                h.offset = val;
                h.dsize  = h.fsize - val;
            end
            SEL_INFO:      h.info_len = val;
            SEL_WIDTH:     h.width = val;
            SEL_HEIGHT:    h.height = val;
            SEL_PLANES:    h.planes = val[15:0];
            SEL_DEPTH:     h.depth = val[15:0];
            SEL_COMP:      h.comp = val;
            SEL_DSIZE:     h.dsize = val;
            SEL_COLORS:    h.colors = val;
            SEL_IMPORTANT: h.important = val;
            default:       ;
        endcase
        return h;
    endfunction

    task automatic parse_byte(input logic [7:0] b, input logic fb);
        logic [31:0] word;
        logic [15:0] half;
        logic        pal;
        logic        tru;
        logic        done;
        status_t     code;
        result_t     r;
        if (fb)
        begin
            p_pos    = 6'd0;
            p_shift  = 32'd0;
            p_offset = 32'd0;
            p_width  = 32'd0;
            p_height = 32'd0;
            p_depth  = 16'd0;
            p_dsize  = 32'd0;
            p_colors = 32'd0;
            p_fsize  = 32'd0;
            p_halted = 1'b0;
        end
        if (p_halted)
            return;
        bytes_parsed++;
        p_shift = {b, p_shift[31:8]};
        word    = p_shift;
        half    = p_shift[31:16];
        pal     = p_depth == DEPTH_PAL;
        tru     = p_depth == DEPTH_TRUE;
        code    = ST_OK;
        done    = 1'b0;
        case (p_pos)
            END_MAGIC:  if (half != BMP_MAGIC) code = ST_SIGNATURE;
            END_FSIZE:
            begin
                p_fsize = word;
                if (word != cfg_size) code = ST_FILE_SIZE;
            end
            END_RSVD:   if (word != 32'd0) code = ST_RESERVED;
            END_OFFSET: p_offset = word;
            END_INFO:   if (word != INFO_LEN) code = ST_VERSION;
            END_WIDTH:
            begin
                p_width = word;
                if (word == 32'd0 || word[31]) code = ST_WIDTH;
            end
            END_HEIGHT:
            begin
                p_height = word;
                if (word == 32'd0) code = ST_HEIGHT;
            end
            END_PLANES: if (half != ONE_PLANE) code = ST_PLANES;
            END_DEPTH:
            begin
                p_depth = half;
                if (half != DEPTH_PAL && half != DEPTH_TRUE) code = ST_BPP;
            end
            END_COMP:   if (word != 32'd0) code = ST_COMPRESSION;
            // size may be left as zero; otherwise it must match, modulo 2^32
            END_DSIZE:
            begin
                p_dsize = word;
                if (word != 32'd0 && word != p_fsize - p_offset) code = ST_PIXEL_SIZE;
            end
            END_COLORS:
            begin
                p_colors = word;
                if (word == 32'd0 && pal)
                    code = ST_NO_COLORS;
                else if (word > PALETTE_MAX && pal)
                    code = ST_MANY_COLORS;
                else if (word != 32'd0 && tru)
                    code = ST_TRUE_COLORS;
            end
            END_LAST:
            begin
                done = 1'b1;
                if (word > PALETTE_MAX && pal) code = ST_IMPORTANT;
            end
            default:    ;
        endcase
        if (done || code != ST_OK)
        begin
            p_halted          = 1'b1;
            r.status          = code;
            r.image_width     = p_width[30:0];
            r.image_height    = p_height;
            r.pixel_bits      = p_depth[4:0];
            r.color_count     = p_colors;
            r.important_count = done ? word : 32'd0;
            r.data_offset     = p_offset;
            r.data_size       = p_dsize;
            verdict_q.push_back(r);
            row_seen = 1'b1;
            row_code = code;
        end
        else
            p_pos = p_pos + 6'd1;
    endtask

    task automatic offer_byte(input logic [7:0] b, input logic fb);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        byte_value <= b;
        first_byte <= fb;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        parse_byte(b, fb);
    endtask

    task automatic send_span(input logic [431:0] v, input int first, input int last);
        for (int i = first; i <= last; i++)
            offer_byte(v[8*i +: 8], i == 0);
    endtask

    // Hold the sender until every awaited verdict is out, then let the parser go quiet
    task automatic settle();
        in_valid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_size(input logic [31:0] v);
        cfg_valid          <= 1'b1;
        measured_file_size <= v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        cfg_size = v;
        size_writes++;
    endtask

    task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (got !== want)
        begin
            fail_count++;
            if (fail_count <= 10)
                $display("%s mismatch: expected %h, got %h", name, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        cycle_count++;
        if (rst_n && out_valid === 1'b1 && !out_stall)
        begin
            if (verdict_q.size() == 0)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unawaited verdict, status %0d", status);
            end
            else
            begin
                due = verdict_q.pop_front();
                check_field("status", 32'(due.status), 32'(status));
                check_field("image_width", 32'(due.image_width), 32'(image_width));
                check_field("image_height", due.image_height, image_height);
                check_field("pixel_bits", 32'(due.pixel_bits), 32'(pixel_bits));
                check_field("color_count", due.color_count, color_count);
                check_field("important_count", due.important_count, important_count);
                check_field("data_offset", due.data_offset, data_offset);
                check_field("data_size", due.data_size, data_size);
                verdicts_checked++;
            end
        end
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("bmp_header_validator_top test failed");
            $finish;
        end
    end

    // Result side: random stall per beat, or one long hold-off when asked
    initial
    begin : verdict_sink
        int n;
        wait (rst_n === 1'b1);
        forever
        begin
            if (hold_req > 0)
            begin
                n = hold_req;
                hold_req = 0;
            end
            else
                n = quiet ? 0 : $urandom_range(0, 4);
            if (n > 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
                out_stall <= 1'b0;
            end
            @(posedge clk);
            while (!(out_valid === 1'b1 && !out_stall)) @(posedge clk);
        end
    end

    initial
    begin : stimulus
        bmp_header_t  h;
        logic [431:0] hv;
        int           hdr_idx;
        int           size_step;
        int           kind;
        logic [31:0]  val;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // parser waits for first_byte out of reset: drop these
        for (int i = 0; i < 3; i++)
            offer_byte(8'($urandom_range(0, 255)), 1'b0);
        settle();
        write_size(DIR_SIZE);

        foreach (plan[r])
        begin
            h = edit_header(base_header(plan[r].true_colour), plan[r].sel, plan[r].val);
            hv = pack_header(h);
            row_seen = 1'b0;
            send_span(hv, 0, int'(plan[r].len) - 1);
            if (plan[r].has_want && (!row_seen || row_code != plan[r].want))
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("header case %0d: status %0d (emitted %0b), table gives %0d",
                             r, row_code, row_seen, plan[r].want);
            end
        end
        // stray bytes after a complete header
        offer_byte(8'hFF, 1'b0);
        offer_byte(8'h00, 1'b0);

        // size register changed between byte 3 and byte 5 of a header
        h = edit_header(base_header(1'b0), SEL_FSIZE, 32'd5000);
        h.dsize = 32'd5000 - h.offset;
        hv = pack_header(h);
        send_span(hv, 0, 3);
        settle();
        write_size(32'd5000);
        send_span(hv, 4, 53);

        hdr_idx       = 0;
        size_step     = 0;
        while (hdr_idx < RANDOM_HEADERS)
        begin
            if (hdr_idx % 3 == 2)
            begin
                settle();
                case (size_step % 4)
                    0:       write_size(32'd0);
                    1:       write_size(32'hFFFFFFFF);
                    2:       write_size($urandom());
                    default: write_size($urandom_range(54, 1 << 20));
                endcase
                size_step++;
            end
            quiet = ($urandom_range(0, 7) == 0);
            if (hdr_idx == 4)
            begin
                // back up the result path behind a long receiver hold-off
                hold_req = 80;
                quiet = 1'b1;
                repeat (12)
                begin
                    h = edit_header(random_header(), SEL_MAGIC, 32'($urandom_range(0, 16'h4D41)));
                    hv = pack_header(h);
                    send_span(hv, 0, 1);
                end
                quiet = 1'b0;
            end
            else
            begin
                h = random_header();
                if ($urandom_range(0, 9) < 4)
                begin
                    case ($urandom_range(0, 2))
                        0:       val = 32'd0;
                        1:       val = 32'd1 << $urandom_range(0, 31);
                        default: val = $urandom();
                    endcase
                    h = edit_header(h, sel_t'($urandom_range(SEL_MAGIC, SEL_IMPORTANT)), val);
                end
                hv = pack_header(h);
                kind = $urandom_range(0, 9);
                if (kind == 0)
                begin
                    repeat ($urandom_range(1, 6))
                        offer_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
                end
                else if (kind == 1)
                    send_span(hv, 0, $urandom_range(0, 52));
                else
                    send_span(hv, 0, 53);
            end
            hdr_idx++;
        end

        quiet = 1'b0;
        in_valid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        fail_count += verdict_q.size();

        $display("%0d header bytes parsed across %0d headers, %0d verdicts checked",
                 bytes_parsed, hdr_idx + 25, verdicts_checked);
        $display("%0d file size settings used, including 0 and all ones", size_writes);
        if (fail_count == 0)
            $display("bmp_header_validator_top test passed");
        else
            $display("bmp_header_validator_top test failed");
        $finish;
    end

endmodule
